FILE: hdl/gror_pkg.sv
// ----------------------------------------------------------------------------
// gror_pkg
// Shared types and constants of the glyph range offset lookup.
// ----------------------------------------------------------------------------
package gror_pkg;

    localparam int CHAR_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 5;
    localparam int ROW_SHIFT  = 3;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_CHAR_WIDTH  = 2'd0;
    localparam cfg_index_t REG_CHAR_HEIGHT = 2'd1;
    localparam cfg_index_t REG_RANGE_COUNT = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0]   first;
        logic [CHAR_W-1:0]   last;
        logic [OFFSET_W-1:0] base;
    } range_entry_t;

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] base;
        logic [CHAR_W-1:0]   delta;
        logic [CHAR_W-1:0]   glen;
    } offset_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_FINISH
    } ctrl_state_t;

endpackage

FILE: hdl/gror_if.sv
// ----------------------------------------------------------------------------
// gror_if
// Channel interfaces: lookup requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface gror_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  entry_index;
    logic [7:0]  range_first;
    logic [7:0]  range_last;
    logic [15:0] range_base;
    logic signed [7:0] character;

    modport source (output valid, operation, entry_index, range_first, range_last,
                    range_base, character, input ready);
    modport sink (input valid, operation, entry_index, range_first, range_last,
                  range_base, character, output ready);
endinterface

interface gror_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] glyph_offset;
    logic        found;

    modport source (output valid, glyph_offset, found, input ready);
    modport sink (input valid, glyph_offset, found, output ready);
endinterface

interface gror_cfg_if;
    logic                     valid;
    logic                     ready;
    gror_pkg::cfg_index_t     index;
    logic [gror_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/gror_table.sv
// ----------------------------------------------------------------------------
// gror_table
// Range table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gror_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  gror_pkg::range_entry_t wr_data,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output gror_pkg::range_entry_t rd_data
);

    gror_pkg::range_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/gror_offset.sv
// ----------------------------------------------------------------------------
// gror_offset
// Offset unit: base plus character delta times glyph length, registered.
// ----------------------------------------------------------------------------
module gror_offset (
    input  logic                              clk,
    input  gror_pkg::offset_req_t             req,
    output logic [gror_pkg::OFFSET_W-1:0]     offset
);

    logic [gror_pkg::OFFSET_W-1:0] product;
    logic [gror_pkg::OFFSET_W-1:0] offset_reg;

    assign product = gror_pkg::OFFSET_W'(req.delta) * gror_pkg::OFFSET_W'(req.glen);

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            offset_reg <= req.base + product;
        end
    end

    assign offset = offset_reg;

endmodule

FILE: hdl/gror_ctrl.sv
// ----------------------------------------------------------------------------
// gror_ctrl
// Request handling, configuration registers, range scan and result register.
// ----------------------------------------------------------------------------
module gror_ctrl #(
    parameter int MAX_RANGES = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gror_req_if.sink                          request,
    gror_res_if.source                        result,
    gror_cfg_if.sink                          cfg,
    output logic                              tbl_wr_en,
    output logic [IDX_W-1:0]                  tbl_wr_addr,
    output gror_pkg::range_entry_t            tbl_wr_data,
    output logic                              tbl_rd_en,
    output logic [IDX_W-1:0]                  tbl_rd_addr,
    input  gror_pkg::range_entry_t            tbl_rd_data,
    output gror_pkg::offset_req_t             off_req,
    input  logic [gror_pkg::OFFSET_W-1:0]     off_value
);

    localparam logic [8:0] MAX9 = 9'(MAX_RANGES);

    gror_pkg::ctrl_state_t state_reg, state_next;

    logic [gror_pkg::CHAR_W-1:0]   width_reg;
    logic [gror_pkg::CHAR_W-1:0]   height_reg;
    logic [gror_pkg::COUNT_W-1:0]  count_reg;

    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic [CNT_W-1:0]              limit_reg, limit_next;
    logic                          pend_reg, pend_next;
    logic                          hit_reg, hit_next;
    logic [gror_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic [gror_pkg::CHAR_W-1:0]   glen_reg, glen_next;
    logic [gror_pkg::CHAR_W-1:0]   delta_reg, delta_next;
    logic [gror_pkg::OFFSET_W-1:0] base_reg, base_next;

    logic                          out_valid_reg, out_valid_next;
    logic [gror_pkg::OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic                          out_found_reg, out_found_next;

    logic                          req_accept;
    logic                          issue;
    logic                          match;
    logic [8:0]                    count9;
    logic [8:0]                    entry9;
    logic [8:0]                    limit9;
    logic [gror_pkg::OFFSET_W-1:0] glen_full;

    assign req_accept = request.valid && request.ready;
    assign count9     = 9'(count_reg);
    assign entry9     = 9'(request.entry_index);
    assign limit9     = (count9 > MAX9) ? MAX9 : count9;
    assign glen_full  = gror_pkg::OFFSET_W'(width_reg)
                      * gror_pkg::OFFSET_W'(height_reg >> gror_pkg::ROW_SHIFT);

    assign tbl_wr_en   = req_accept && (request.operation == gror_pkg::OP_LOAD)
                       && (entry9 < MAX9);
    assign tbl_wr_addr = entry9[IDX_W-1:0];
    assign tbl_wr_data = '{first: request.range_first, last: request.range_last,
                           base: request.range_base};

    assign issue       = (state_reg == gror_pkg::ST_SCAN) && (issue_reg < limit_reg);
    assign tbl_rd_en   = issue;
    assign tbl_rd_addr = issue_reg[IDX_W-1:0];

    // Negative codes never fall inside a range.
    assign match = pend_reg && !char_reg[gror_pkg::CHAR_W-1]
                 && (char_reg >= tbl_rd_data.first) && (char_reg <= tbl_rd_data.last);

    assign off_req = '{start: (state_reg == gror_pkg::ST_MUL), base: base_reg,
                       delta: delta_reg, glen: glen_reg};

    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.glyph_offset = out_offset_reg;
    assign result.found        = out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd8;
            height_reg <= 8'd8;
            count_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                gror_pkg::REG_CHAR_WIDTH:  width_reg  <= cfg.data;
                gror_pkg::REG_CHAR_HEIGHT: height_reg <= cfg.data;
                gror_pkg::REG_RANGE_COUNT: count_reg  <= cfg.data[gror_pkg::COUNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gror_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            issue_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            issue_reg     <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg      <= limit_next;
        hit_reg        <= hit_next;
        char_reg       <= char_next;
        glen_reg       <= glen_next;
        delta_reg      <= delta_next;
        base_reg       <= base_next;
        out_offset_reg <= out_offset_next;
        out_found_reg  <= out_found_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        limit_next      = limit_reg;
        pend_next       = 1'b0;
        hit_next        = hit_reg;
        char_next       = char_reg;
        glen_next       = glen_reg;
        delta_next      = delta_reg;
        base_next       = base_reg;
        out_offset_next = out_offset_reg;
        out_found_next  = out_found_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        request.ready   = 1'b0;

        unique case (state_reg)
            gror_pkg::ST_IDLE:
            begin
                request.ready = 1'b1;
                if (req_accept)
                begin
                    hit_next   = 1'b0;
                    char_next  = request.character;
                    glen_next  = glen_full[gror_pkg::CHAR_W-1:0];
                    limit_next = limit9[CNT_W-1:0];
                    issue_next = '0;
                    if (request.operation == gror_pkg::OP_LOOKUP)
                    begin
                        state_next = gror_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = gror_pkg::ST_FINISH;
                    end
                end
            end

            gror_pkg::ST_SCAN:
            begin
                priority if (match)
                begin
                    hit_next   = 1'b1;
                    delta_next = char_reg - tbl_rd_data.first;
                    base_next  = tbl_rd_data.base;
                    state_next = gror_pkg::ST_MUL;
                end
                else if (issue)
                begin
                    pend_next  = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = gror_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = gror_pkg::ST_SCAN;
                end
            end

            gror_pkg::ST_MUL:
            begin
                state_next = gror_pkg::ST_FINISH;
            end

            gror_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = hit_reg && (off_value != '0);
                    out_offset_next = hit_reg ? off_value : '0;
                    state_next      = gror_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gror_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/glyph_range_offset_lookup_top.sv
// ----------------------------------------------------------------------------
// glyph_range_offset_lookup_top
// Looks up the glyph byte offset of a character in a table of code ranges.
//
//   Channel   Direction  Transaction
//   request   in         load one range entry or look up one character
//   result    out        glyph_offset and found, one per request
//   cfg       in         write char_width, char_height or range_count
//
// A load goes from acceptance straight to the result register. A lookup reads
// its n searched entries one at a time, n = range_count capped at MAX_RANGES,
// stops at the first match and registers its offset; with no match it misses.
// The table memory's single read port sets this scan length.
// Reset sets only FSM and config registers; table entries start undefined.
// A stalled result holds in the output register while the next request runs.
// ----------------------------------------------------------------------------
module glyph_range_offset_lookup_top #(
    parameter int MAX_RANGES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    gror_req_if.sink   request,
    gror_res_if.source result,
    gror_cfg_if.sink   cfg
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    logic                          tbl_wr_en;
    logic [IDX_W-1:0]              tbl_wr_addr;
    gror_pkg::range_entry_t        tbl_wr_data;
    logic                          tbl_rd_en;
    logic [IDX_W-1:0]              tbl_rd_addr;
    gror_pkg::range_entry_t        tbl_rd_data;
    gror_pkg::offset_req_t         off_req;
    logic [gror_pkg::OFFSET_W-1:0] off_value;

    gror_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .result      (result),
        .cfg         (cfg),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .off_req     (off_req),
        .off_value   (off_value)
    );

    gror_table #(
        .DEPTH (MAX_RANGES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    gror_offset u_offset (
        .clk    (clk),
        .req    (off_req),
        .offset (off_value)
    );

endmodule

FILE: hdl/gror_checker.sv
// ----------------------------------------------------------------------------
// gror_checker
// Port-level assertions for the glyph range offset lookup.
// ----------------------------------------------------------------------------
module gror_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] glyph_offset,
    input logic        found
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(glyph_offset) && $stable(found))
        else $error("Stalled result changed.");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && found |-> glyph_offset != 16'd0)
        else $error("Found result carries a zero offset.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> glyph_offset == 16'd0)
        else $error("Not-found result carries a nonzero offset.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request taken while the previous one is still in work.");

endmodule

bind glyph_range_offset_lookup_top gror_checker u_gror_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .glyph_offset (result.glyph_offset),
    .found        (result.found)
);
